### rtl/smap_pkg.sv
// Package: shared types and constants for the STUN mapped-address parser.
package smap_pkg;

  localparam int unsigned MaxBytesDefault = 1024;

  localparam int unsigned HdrLen = 20;
  localparam logic [31:0] MagicCookie = 32'h2112A442;
  localparam logic [15:0] AttrTypePlain = 16'h0001;
  localparam logic [15:0] AttrTypeXor = 16'h0020;
  localparam logic [15:0] MinAddrLen = 16'd8;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_ATTR_HDR = 2'd1,
    PH_SKIP     = 2'd2,
    PH_CAPTURE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_SHORT = 2'd1,
    ST_NONE  = 2'd2
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [16:0] bytes_left;
    logic        captured;
    logic        cand_xor;
    logic [7:0]  cand_family;
    logic [15:0] cand_port;
    logic [31:0] cand_ip;
    logic [16:0] cand_end;
  } walk_state_t;

  localparam walk_state_t WalkReset = '{
    phase:       PH_HEADER,
    attr_type:   16'd0,
    attr_len:    16'd0,
    bytes_left:  17'd0,
    captured:    1'b0,
    cand_xor:    1'b0,
    cand_family: 8'd0,
    cand_port:   16'd0,
    cand_ip:     32'd0,
    cand_end:    17'd0
  };

endpackage

### rtl/smap_attr_walk.sv
// Per-byte next-state logic of the attribute walk (header skip, TLV walk, capture).
module smap_attr_walk import smap_pkg::*; #(
  parameter int unsigned CntW = 11
) (
  input  logic [CntW-1:0] byte_count_i,  // count including the current byte
  input  logic [7:0]      data_byte_i,
  input  walk_state_t     state_i,
  output walk_state_t     state_o
);

  logic [1:0]  hdr_idx;
  logic [2:0]  hdr_left;
  logic [15:0] type_nxt;
  logic [15:0] len_nxt;
  logic [16:0] padded;
  logic [3:0]  cap_off;

  always_comb begin
    hdr_left = state_i.bytes_left[2:0] - 3'd1;
    hdr_idx  = 2'(3'd4 - state_i.bytes_left[2:0]);
    type_nxt = state_i.attr_type;
    len_nxt  = state_i.attr_len;
    if (!hdr_idx[1]) begin
      type_nxt = {state_i.attr_type[7:0], data_byte_i};
    end else begin
      len_nxt = {state_i.attr_len[7:0], data_byte_i};
    end
    padded  = (17'(len_nxt) + 17'd3) & ~17'd3;
    cap_off = 4'(5'd8 - 5'(state_i.bytes_left));
  end

  always_comb begin
    state_o = state_i;
    case (state_i.phase)
      PH_HEADER: begin
        if (byte_count_i >= CntW'(HdrLen)) begin
          state_o.phase      = PH_ATTR_HDR;
          state_o.bytes_left = 17'd4;
        end
      end
      PH_ATTR_HDR: begin
        state_o.attr_type  = type_nxt;
        state_o.attr_len   = len_nxt;
        state_o.bytes_left = 17'(hdr_left);
        if (hdr_left == 3'd0) begin
          if ((type_nxt == AttrTypePlain || type_nxt == AttrTypeXor) &&
              len_nxt >= MinAddrLen) begin
            state_o.captured   = 1'b1;
            state_o.cand_xor   = (type_nxt == AttrTypeXor);
            state_o.cand_end   = 17'(byte_count_i) + 17'(len_nxt);
            state_o.phase      = PH_CAPTURE;
            state_o.bytes_left = 17'd8;
          end else if (padded == 17'd0) begin
            state_o.bytes_left = 17'd4;
          end else begin
            state_o.phase      = PH_SKIP;
            state_o.bytes_left = padded;
          end
        end
      end
      PH_SKIP: begin
        if (state_i.bytes_left <= 17'd1) begin
          state_o.phase      = PH_ATTR_HDR;
          state_o.bytes_left = 17'd4;
        end else begin
          state_o.bytes_left = state_i.bytes_left - 17'd1;
        end
      end
      PH_CAPTURE: begin
        // value bytes: reserved, family, port (2), address (4)
        if (state_i.bytes_left != 17'd0 && state_i.bytes_left <= 17'd8) begin
          if (cap_off == 4'd1) begin
            state_o.cand_family = data_byte_i;
          end else if (cap_off == 4'd2 || cap_off == 4'd3) begin
            state_o.cand_port = {state_i.cand_port[7:0], data_byte_i};
          end else if (cap_off >= 4'd4) begin
            state_o.cand_ip = {state_i.cand_ip[23:0], data_byte_i};
          end
          state_o.bytes_left = state_i.bytes_left - 17'd1;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

### rtl/stun_mapped_address_parser_core.sv
// Top level: STUN mapped-address parser, one message byte per transfer.
//
// Input channel: one message byte per transfer (data_byte_i) with last_byte_i
// on the final byte. The first 20 bytes are the STUN header; after it the
// attributes are walked and the first MAPPED-ADDRESS or XOR-MAPPED-ADDRESS
// with length of at least 8 is captured (XOR form unmasked with the cookie).
// Bytes past MAX_BYTES are ignored except for their last flag.
// Output channel: one result per message, registered, valid in the cycle after
// the transfer of the last byte.
// Throughput: one byte per cycle; the per-byte step is a single pass of logic
// between the walk state registers and the result register.
// When the receiver stalls, the result holds in the output register; bytes
// keep flowing, and only a last byte is held off until the result is taken.
// Reset clears the walk state and the output valid; the walk state also
// returns to reset after every last byte, ready for the next message.
module stun_mapped_address_parser_core import smap_pkg::*; #(
  parameter int unsigned MAX_BYTES = MaxBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        xor_form_o,
  output logic [7:0]  addr_family_o,
  output logic [15:0] mapped_port_o,
  output logic [31:0] mapped_ip_o
);

  localparam int unsigned CntW = $clog2(MAX_BYTES + 1);

  logic [CntW-1:0] byte_count_q, byte_count_d, count_inc;
  walk_state_t     walk_q, walk_d, walk_step;
  logic            in_xfer, counted, done;

  logic            out_valid_q, out_valid_d;
  status_e         status_q, status_d;
  logic            xor_form_q, xor_form_d;
  logic [7:0]      family_q, family_d;
  logic [15:0]     port_q, port_d;
  logic [31:0]     ip_q, ip_d;

  assign in_stall_o = out_valid_q && out_stall_i && last_byte_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign done       = in_xfer && last_byte_i;
  assign counted    = byte_count_q < CntW'(MAX_BYTES);
  assign count_inc  = byte_count_q + CntW'(1);

  smap_attr_walk #(
    .CntW(CntW)
  ) u_walk (
    .byte_count_i(count_inc),
    .data_byte_i (data_byte_i),
    .state_i     (walk_q),
    .state_o     (walk_step)
  );

  // next walk state and result fields
  always_comb begin
    byte_count_d = byte_count_q;
    walk_d       = walk_q;
    if (in_xfer && counted) begin
      byte_count_d = count_inc;
      walk_d       = walk_step;
    end

    status_d   = ST_NONE;
    xor_form_d = 1'b0;
    family_d   = 8'd0;
    port_d     = 16'd0;
    ip_d       = 32'd0;
    if (byte_count_d < CntW'(HdrLen)) begin
      status_d = ST_SHORT;
    end else if (walk_d.captured && walk_d.cand_end <= 17'(byte_count_d)) begin
      status_d   = ST_FOUND;
      xor_form_d = walk_d.cand_xor;
      family_d   = walk_d.cand_family;
      if (walk_d.cand_xor) begin
        port_d = walk_d.cand_port ^ MagicCookie[31:16];
        ip_d   = walk_d.cand_ip ^ MagicCookie;
      end else begin
        port_d = walk_d.cand_port;
        ip_d   = walk_d.cand_ip;
      end
    end

    if (done) begin
      byte_count_d = '0;
      walk_d       = WalkReset;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (done) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      walk_q       <= WalkReset;
      out_valid_q  <= 1'b0;
    end else begin
      byte_count_q <= byte_count_d;
      walk_q       <= walk_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      status_q   <= status_d;
      xor_form_q <= xor_form_d;
      family_q   <= family_d;
      port_q     <= port_d;
      ip_q       <= ip_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign xor_form_o    = xor_form_q;
  assign addr_family_o = family_q;
  assign mapped_port_o = port_q;
  assign mapped_ip_o   = ip_q;

  a_result_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) |=> out_valid_o)
    else $error("no result after last byte transfer");

  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) |=> (byte_count_q == '0))
    else $error("byte count not cleared after message end");

  a_header_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (walk_q.phase != PH_HEADER) |-> (byte_count_q >= CntW'(HdrLen)))
    else $error("attribute walk started inside the header");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_FOUND) |->
      (!xor_form_o && addr_family_o == 8'd0 && mapped_port_o == 16'd0 &&
       mapped_ip_o == 32'd0))
    else $error("address fields set without a found address");

endmodule
